// ===== rtl/video_port_access_engine_unit_macros.svh =====
// ----------------------------------------------------------------------------
// video port access engine assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef VIDEO_PORT_ACCESS_ENGINE_UNIT_MACROS_SVH
`define VIDEO_PORT_ACCESS_ENGINE_UNIT_MACROS_SVH

// property checked only while out of reset
`define VPAE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define VPAE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/vpae_pkg.sv =====
// ----------------------------------------------------------------------------
// vpae_pkg
// types, constants and codes of the video port access engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vpae_pkg;

    localparam int VIDEO_RAM_BYTES = 65536;
    localparam int SCROLL_ENTRIES  = 40;
    localparam int MODE_REG_COUNT  = 24;

    localparam int CRAM_DEPTH = 64;
    localparam int VRAM_PAIRS = VIDEO_RAM_BYTES / 2;
    localparam int VRAM_AW    = $clog2(VIDEO_RAM_BYTES) - 1;
    localparam int SCR_AW     = (SCROLL_ENTRIES > 1) ? $clog2(SCROLL_ENTRIES) : 1;

    localparam logic [6:0] SCROLL_LIMIT = 7'(SCROLL_ENTRIES);
    localparam bit         HAS_INC      = (MODE_REG_COUNT > 15);
    localparam logic [4:0] INC_REG      = 5'd15;

    localparam logic [1:0]  MODE_WR_TAG = 2'b10;
    localparam logic [15:0] CRAM_MASK   = 16'h0EEE;
    localparam logic [15:0] SRAM_MASK   = 16'h07FF;

    localparam logic [3:0] CODE_VRAM_WR = 4'h1;
    localparam logic [3:0] CODE_CRAM_WR = 4'h3;
    localparam logic [3:0] CODE_SRAM_WR = 4'h5;
    localparam logic [3:0] CODE_VRAM_RD = 4'h0;
    localparam logic [3:0] CODE_CRAM_RD = 4'h8;
    localparam logic [3:0] CODE_SRAM_RD = 4'h4;

    typedef enum logic [1:0] {
        FUNC_CTRL_WR   = 2'd0,
        FUNC_DATA_WR   = 2'd1,
        FUNC_DATA_RD   = 2'd2,
        FUNC_STATUS_RD = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        SRC_ZERO = 2'd0,
        SRC_VRAM = 2'd1,
        SRC_CRAM = 2'd2,
        SRC_SRAM = 2'd3
    } t_src;

    typedef struct packed {
        logic               vram_we;
        logic               cram_we;
        logic               sram_we;
        logic               refill;
        t_src               src;
        logic               result;
        logic               status;
        logic [VRAM_AW-1:0] vram_addr;
        logic [5:0]         idx;
        logic [15:0]        wdata;
    } t_mem_req;

endpackage

// ===== rtl/vpae_ram.sv =====
// ----------------------------------------------------------------------------
// vpae_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vpae_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/vpae_regs.sv =====
// ----------------------------------------------------------------------------
// vpae_regs
// access address, access code, second word latch and increment register;
// decodes one port access into a memory request
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vpae_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [1:0]         i_func,
    input  logic [15:0]        i_word,
    output vpae_pkg::t_mem_req o_req
);

    logic [15:0] r_addr, n_addr;
    logic [5:0]  r_code, n_code;
    logic        r_pending, n_pending;
    logic [7:0]  r_inc, n_inc;

    logic [15:0] w_next_addr;
    logic [5:0]  w_idx;
    logic        w_scroll_ok;
    logic [15:0] w_swapped;
    vpae_pkg::t_mem_req w_req;

    assign w_next_addr = r_addr + {8'd0, r_inc};
    assign w_idx       = r_addr[6:1];
    assign w_scroll_ok = ({1'b0, w_idx} < vpae_pkg::SCROLL_LIMIT);
    assign w_swapped   = r_addr[0] ? {i_word[7:0], i_word[15:8]} : i_word;

    always_comb begin
        n_addr    = r_addr;
        n_code    = r_code;
        n_pending = r_pending;
        n_inc     = r_inc;

        w_req           = '0;
        w_req.src       = vpae_pkg::SRC_ZERO;
        w_req.vram_addr = r_addr[vpae_pkg::VRAM_AW:1];
        w_req.idx       = w_idx;
        w_req.wdata     = w_swapped;

        unique case (vpae_pkg::t_func'(i_func))
            vpae_pkg::FUNC_CTRL_WR: begin
                if (!r_pending) begin
                    if (i_word[15:14] == vpae_pkg::MODE_WR_TAG) begin
                        if (vpae_pkg::HAS_INC && i_word[12:8] == vpae_pkg::INC_REG) begin
                            n_inc = i_word[7:0];
                        end
                    end else begin
                        n_code[1:0]  = i_word[15:14];
                        n_addr[13:0] = i_word[13:0];
                        n_pending    = 1'b1;
                    end
                end else begin
                    n_code[5:2]   = i_word[7:4];
                    n_addr[15:14] = i_word[1:0];
                    n_pending     = 1'b0;
                end
            end
            vpae_pkg::FUNC_DATA_WR: begin
                n_pending = 1'b0;
                unique case (r_code[3:0])
                    vpae_pkg::CODE_VRAM_WR: begin
                        w_req.vram_we = 1'b1;
                        n_addr        = w_next_addr;
                    end
                    vpae_pkg::CODE_CRAM_WR: begin
                        w_req.cram_we = 1'b1;
                        w_req.wdata   = i_word & vpae_pkg::CRAM_MASK;
                        n_addr        = w_next_addr;
                    end
                    vpae_pkg::CODE_SRAM_WR: begin
                        w_req.sram_we = w_scroll_ok;
                        w_req.wdata   = i_word & vpae_pkg::SRAM_MASK;
                        n_addr        = w_next_addr;
                    end
                    default: begin
                    end
                endcase
            end
            vpae_pkg::FUNC_DATA_RD: begin
                n_pending    = 1'b0;
                w_req.refill = 1'b1;
                w_req.result = 1'b1;
                unique case (r_code[3:0])
                    vpae_pkg::CODE_VRAM_RD: begin
                        w_req.src = vpae_pkg::SRC_VRAM;
                        n_addr    = w_next_addr;
                    end
                    vpae_pkg::CODE_CRAM_RD: begin
                        w_req.src = vpae_pkg::SRC_CRAM;
                        n_addr    = w_next_addr;
                    end
                    vpae_pkg::CODE_SRAM_RD: begin
                        w_req.src = w_scroll_ok ? vpae_pkg::SRC_SRAM : vpae_pkg::SRC_ZERO;
                        n_addr    = w_next_addr;
                    end
                    default: begin
                    end
                endcase
            end
            vpae_pkg::FUNC_STATUS_RD: begin
                n_pending    = 1'b0;
                w_req.result = 1'b1;
                w_req.status = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr    <= '0;
            r_code    <= '0;
            r_pending <= 1'b0;
            r_inc     <= '0;
        end else if (i_fire) begin
            r_addr    <= n_addr;
            r_code    <= n_code;
            r_pending <= n_pending;
            r_inc     <= n_inc;
        end
    end

    assign o_req = w_req;

endmodule

// ===== rtl/video_port_access_engine_unit.sv =====
// ----------------------------------------------------------------------------
// video_port_access_engine_unit
// control and data port access engine of a video display processor
// ----------------------------------------------------------------------------
// input stream: one beat per port access; tuser carries the access kind
// (control write, data write, data read, status read), tdata the bus word.
// output stream: one beat for each data read (prefetch buffer contents before
// the refill) and each status read (zero); writes give no beat.
// a beat is taken into an input register, then executed against the port
// registers and memories, and its result is placed in the output register.
// one access per cycle is sustained unless a read or status access finds
// the output register full; each access touches one word of one memory,
// and a prefetch refill lands in the buffer in the cycle after its issue.
// reset clears the address, code, latch, increment, prefetch buffer and both
// register stages; memory contents are left as they are.
// when the receiver stalls, the result beat holds; writes keep flowing until
// a further read or status access finds the output register still full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module video_port_access_engine_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] bus_word
    input  logic [1:0]  i_s_tuser,   // [1:0] func
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata    // [15:0] read_word
);

    logic        r_in_valid;
    logic [1:0]  r_in_func;
    logic [15:0] r_in_word;

    logic        r_out_valid;
    logic [15:0] r_out_data;

    logic        r_pf_pend;
    vpae_pkg::t_src r_pf_src;
    logic [15:0] r_prefetch;

    logic        w_fire;
    logic        w_in_take;
    logic [15:0] w_prefetch;
    vpae_pkg::t_mem_req w_req;

    logic [7:0]  w_vram_hi, w_vram_lo;
    logic [11:0] w_cram_q;
    logic [10:0] w_sram_q;

    assign w_fire = r_in_valid && (!w_req.result || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_fire;
    assign w_in_take  = i_s_tvalid && o_s_tready;

    vpae_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_func  (r_in_func),
        .i_word  (r_in_word),
        .o_req   (w_req)
    );

    vpae_ram #(.WIDTH(8), .DEPTH(vpae_pkg::VRAM_PAIRS)) u_vram_even (
        .i_clk   (i_clk),
        .i_we    (w_fire && w_req.vram_we),
        .i_waddr (w_req.vram_addr),
        .i_wdata (w_req.wdata[15:8]),
        .i_re    (w_fire && w_req.refill && w_req.src == vpae_pkg::SRC_VRAM),
        .i_raddr (w_req.vram_addr),
        .o_rdata (w_vram_hi)
    );

    vpae_ram #(.WIDTH(8), .DEPTH(vpae_pkg::VRAM_PAIRS)) u_vram_odd (
        .i_clk   (i_clk),
        .i_we    (w_fire && w_req.vram_we),
        .i_waddr (w_req.vram_addr),
        .i_wdata (w_req.wdata[7:0]),
        .i_re    (w_fire && w_req.refill && w_req.src == vpae_pkg::SRC_VRAM),
        .i_raddr (w_req.vram_addr),
        .o_rdata (w_vram_lo)
    );

    vpae_ram #(.WIDTH(12), .DEPTH(vpae_pkg::CRAM_DEPTH)) u_cram (
        .i_clk   (i_clk),
        .i_we    (w_fire && w_req.cram_we),
        .i_waddr (w_req.idx),
        .i_wdata (w_req.wdata[11:0]),
        .i_re    (w_fire && w_req.refill && w_req.src == vpae_pkg::SRC_CRAM),
        .i_raddr (w_req.idx),
        .o_rdata (w_cram_q)
    );

    vpae_ram #(.WIDTH(11), .DEPTH(vpae_pkg::SCROLL_ENTRIES)) u_sram (
        .i_clk   (i_clk),
        .i_we    (w_fire && w_req.sram_we),
        .i_waddr (w_req.idx[vpae_pkg::SCR_AW-1:0]),
        .i_wdata (w_req.wdata[10:0]),
        .i_re    (w_fire && w_req.refill && w_req.src == vpae_pkg::SRC_SRAM),
        .i_raddr (w_req.idx[vpae_pkg::SCR_AW-1:0]),
        .o_rdata (w_sram_q)
    );

    // refill data arrives in the cycle after issue
    always_comb begin
        w_prefetch = r_prefetch;
        if (r_pf_pend) begin
            case (r_pf_src)
                vpae_pkg::SRC_VRAM: w_prefetch = {w_vram_hi, w_vram_lo};
                vpae_pkg::SRC_CRAM: w_prefetch = {4'd0, w_cram_q};
                vpae_pkg::SRC_SRAM: w_prefetch = {5'd0, w_sram_q};
                default:            w_prefetch = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pf_pend   <= 1'b0;
            r_prefetch  <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_fire && w_req.result) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            r_prefetch <= w_prefetch;
            r_pf_pend  <= w_fire && w_req.refill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_func <= i_s_tuser;
            r_in_word <= i_s_tdata;
        end
        if (w_fire && w_req.result) begin
            r_out_data <= w_req.status ? 16'd0 : w_prefetch;
        end
        if (w_fire && w_req.refill) begin
            r_pf_src <= w_req.src;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ===== rtl/vpae_checker.sv =====
// ----------------------------------------------------------------------------
// vpae_checker
// port level checks of the video port access engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "video_port_access_engine_unit_macros.svh"

module vpae_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata
);

    `VPAE_ASSERT_ALWAYS(a_rst_clears_out, !i_rst_n |=> !o_m_tvalid, "result beat after reset")
    `VPAE_ASSERT_ALWAYS(a_rst_ready, $past(!i_rst_n) |-> o_s_tready, "not ready after reset")
    `VPAE_ASSERT(a_ready_with_room, (i_m_tready || !o_m_tvalid) |-> o_s_tready, "input stalled with output room")
    `VPAE_ASSERT(a_out_hold, (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)), "stalled result beat changed")

endmodule

bind video_port_access_engine_unit vpae_checker u_vpae_checker (.*);

// ===== test/video_port_access_engine_unit_test.sv =====
// ----------------------------------------------------------------------------
// video_port_access_engine_unit_test
// streams port accesses into the engine and checks every read and status
// beat against a shadow of the port registers and memories. a directed
// opening covers wrap, byte swap, scroll bounds, ignored registers and the
// latch, then random address setups with write and read bursts follow, with
// random gaps on both sides and long receiver hold-offs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module video_port_access_engine_unit_test;

    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 2000;
    localparam int HOLD_CYCLES  = 250;

    typedef struct {
        vpae_pkg::t_func kind;
        logic [15:0]     word;
    } t_port_access;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata  = '0;   // [15:0] bus_word
    logic [1:0]  i_s_tuser  = '0;   // [1:0] func
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;         // [15:0] read_word

    // shadow of the engine
    logic [7:0]  vram_img    [vpae_pkg::VIDEO_RAM_BYTES];
    bit          vram_seen   [vpae_pkg::VIDEO_RAM_BYTES];
    logic [11:0] cram_img    [vpae_pkg::CRAM_DEPTH];
    bit          cram_seen   [vpae_pkg::CRAM_DEPTH];
    logic [10:0] scroll_img  [vpae_pkg::SCROLL_ENTRIES];
    bit          scroll_seen [vpae_pkg::SCROLL_ENTRIES];
    logic [7:0]  mode_img    [32] = '{default: 8'h00};
    logic [15:0] port_addr     = '0;
    logic [5:0]  port_code     = '0;
    bit          latch_pending = 1'b0;
    logic [15:0] prefetch_word = '0;

    logic [15:0]  read_words_due [$];
    t_port_access access_queue [$];

    int  n_offered   = 0;
    int  n_accepted  = 0;
    int  n_results   = 0;
    int  n_errors    = 0;
    int  in_gap      = 0;
    int  out_gap     = 0;
    int  hold_left   = 0;
    int  holds_taken = 0;
    int  stall_count = 0;
    bit  beat_loaded = 1'b0;
    bit  calm_in     = 1'b0;
    bit  calm_out    = 1'b0;

    video_port_access_engine_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #10 i_clk = ~i_clk;

    function automatic int unsigned vram_slot(input int unsigned byte_addr);
        return byte_addr % vpae_pkg::VIDEO_RAM_BYTES;
    endfunction

    // true when a data read now would refill only from written entries
    function automatic bit refill_known();
        logic [5:0]  idx;
        logic [15:0] even;
        idx  = port_addr[6:1];
        even = {port_addr[15:1], 1'b0};
        case (port_code[3:0])
            vpae_pkg::CODE_VRAM_RD:
                return vram_seen[vram_slot(even)] && vram_seen[vram_slot(even + 1)];
            vpae_pkg::CODE_CRAM_RD: return cram_seen[idx];
            vpae_pkg::CODE_SRAM_RD:
                return (idx >= vpae_pkg::SCROLL_ENTRIES) || scroll_seen[idx];
            default:      return 1'b1;
        endcase
    endfunction

    function automatic void execute_port_access(input vpae_pkg::t_func kind,
                                                input logic [15:0] w);
        logic [15:0] sw;
        logic [5:0]  idx;
        logic [15:0] even;
        logic [7:0]  inc;
        idx  = port_addr[6:1];
        even = {port_addr[15:1], 1'b0};
        inc  = (vpae_pkg::MODE_REG_COUNT > 15) ? mode_img[15] : 8'h00;
        case (kind)
            vpae_pkg::FUNC_CTRL_WR: begin
                if (latch_pending) begin
                    port_code[5:2]   = w[7:4];
                    port_addr[15:14] = w[1:0];
                    latch_pending    = 1'b0;
                end else if (w[15:14] == vpae_pkg::MODE_WR_TAG) begin
                    if (w[12:8] < vpae_pkg::MODE_REG_COUNT) mode_img[w[12:8]] = w[7:0];
                end else begin
                    port_code[1:0]  = w[15:14];
                    port_addr[13:0] = w[13:0];
                    latch_pending   = 1'b1;
                end
            end
            vpae_pkg::FUNC_DATA_WR: begin
                latch_pending = 1'b0;
                case (port_code[3:0])
                    vpae_pkg::CODE_VRAM_WR: begin
                        sw = port_addr[0] ? {w[7:0], w[15:8]} : w;
                        vram_img[vram_slot(even)]      = sw[15:8];
                        vram_img[vram_slot(even + 1)]  = sw[7:0];
                        vram_seen[vram_slot(even)]     = 1'b1;
                        vram_seen[vram_slot(even + 1)] = 1'b1;
                        port_addr = port_addr + 16'(inc);
                    end
                    vpae_pkg::CODE_CRAM_WR: begin
                        cram_img[idx]  = 12'(w & vpae_pkg::CRAM_MASK);
                        cram_seen[idx] = 1'b1;
                        port_addr = port_addr + 16'(inc);
                    end
                    vpae_pkg::CODE_SRAM_WR: begin
                        if (idx < vpae_pkg::SCROLL_ENTRIES) begin
                            scroll_img[idx]  = 11'(w & vpae_pkg::SRAM_MASK);
                            scroll_seen[idx] = 1'b1;
                        end
                        port_addr = port_addr + 16'(inc);
                    end
                    default: ;
                endcase
            end
            vpae_pkg::FUNC_DATA_RD: begin
                latch_pending = 1'b0;
                read_words_due.push_back(prefetch_word);
                case (port_code[3:0])
                    vpae_pkg::CODE_VRAM_RD: begin
                        prefetch_word = {vram_img[vram_slot(even)],
                                         vram_img[vram_slot(even + 1)]};
                        port_addr = port_addr + 16'(inc);
                    end
                    vpae_pkg::CODE_CRAM_RD: begin
                        prefetch_word = {4'h0, cram_img[idx]};
                        port_addr = port_addr + 16'(inc);
                    end
                    vpae_pkg::CODE_SRAM_RD: begin
                        prefetch_word = (idx < vpae_pkg::SCROLL_ENTRIES) ?
                                        {5'h00, scroll_img[idx]} : 16'h0000;
                        port_addr = port_addr + 16'(inc);
                    end
                    default: prefetch_word = 16'h0000;
                endcase
            end
            default: begin
                latch_pending = 1'b0;
                read_words_due.push_back(16'h0000);
            end
        endcase
    endfunction

    // queues one access once the shadow has caught up with all earlier ones
    task automatic offer(input vpae_pkg::t_func kind, input logic [15:0] word);
        t_port_access acc;
        wait (n_accepted == n_offered);
        if (kind == vpae_pkg::FUNC_DATA_RD && !refill_known()) kind = vpae_pkg::FUNC_STATUS_RD;
        acc.kind = kind;
        acc.word = word;
        access_queue.push_back(acc);
        n_offered++;
    endtask

    task automatic clear_latch();
        wait (n_accepted == n_offered);
        if (latch_pending) offer(vpae_pkg::FUNC_STATUS_RD, 16'($urandom));
    endtask

    task automatic point_port(input logic [5:0] code, input logic [15:0] addr);
        logic [15:0] w2;
        clear_latch();
        if (code[1:0] == vpae_pkg::MODE_WR_TAG) code[1] = 1'b0;
        offer(vpae_pkg::FUNC_CTRL_WR, {code[1:0], addr[13:0]});
        w2       = 16'($urandom);
        w2[7:4]  = code[5:2];
        w2[1:0]  = addr[15:14];
        offer(vpae_pkg::FUNC_CTRL_WR, w2);
    endtask

    task automatic write_mode_reg(input logic [4:0] reg_num, input logic [7:0] value);
        clear_latch();
        offer(vpae_pkg::FUNC_CTRL_WR, {vpae_pkg::MODE_WR_TAG, 1'($urandom), reg_num, value});
    endtask

    function automatic logic [7:0] pick_increment();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'h01;
            2, 3:    return 8'h02;
            4:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // video ram traffic mostly stays in three windows so reads find data
    function automatic logic [15:0] pick_addr(input bit to_vram);
        logic [15:0] base;
        if (!to_vram || $urandom_range(0, 9) == 0) return 16'($urandom);
        case ($urandom_range(0, 2))
            0:       base = 16'h0000;
            1:       base = 16'h7FC0;
            default: base = 16'hFFC0;
        endcase
        return base + 16'($urandom_range(0, 63));
    endfunction

    // sender
    always @(negedge i_clk) begin
        t_port_access acc;
        if (!beat_loaded) begin
            if (in_gap > 0) begin
                in_gap--;
                i_s_tvalid <= 1'b0;
            end else if (access_queue.size() > 0) begin
                acc = access_queue.pop_front();
                i_s_tdata   <= acc.word;
                i_s_tuser   <= acc.kind;
                i_s_tvalid  <= 1'b1;
                beat_loaded = 1'b1;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            execute_port_access(vpae_pkg::t_func'(i_s_tuser), i_s_tdata);
            beat_loaded = 1'b0;
            n_accepted++;
            if (n_accepted % 40 == 0) calm_in = ($urandom_range(0, 3) == 0);
            in_gap = calm_in ? 0 : $urandom_range(0, 6);
        end
    end

    // receiver ready, with gaps and long hold-offs
    always @(negedge i_clk) begin
        if (holds_taken < 2 && n_accepted >= 600 * (holds_taken + 1)) begin
            hold_left = HOLD_CYCLES;
            holds_taken++;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        logic [15:0] want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (read_words_due.size() == 0) begin
                n_errors++;
                $display("%0t: read_word beat with none due, expected none, actual %h",
                         $time, o_m_tdata);
            end else begin
                want = read_words_due.pop_front();
                if (o_m_tdata !== want) begin
                    n_errors++;
                    $display("%0t: read_word mismatch, expected %h, actual %h",
                             $time, want, o_m_tdata);
                end
            end
            n_results++;
            if (n_results % 40 == 0) calm_out = ($urandom_range(0, 3) == 0);
            out_gap = calm_out ? 0 : $urandom_range(0, 6);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_count = 0;
        end else begin
            stall_count++;
            if (stall_count >= STALL_LIMIT) begin
                $display("video_port_access_engine_unit_test: done, errors");
                $finish;
            end
        end
    end

    initial begin
        int          sel;
        int          n;
        logic [3:0]  c4;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed opening
        offer(vpae_pkg::FUNC_STATUS_RD, 16'hFFFF);
        write_mode_reg(vpae_pkg::INC_REG, 8'h02);
        point_port({2'b11, vpae_pkg::CODE_VRAM_WR}, 16'hFFFE);
        offer(vpae_pkg::FUNC_DATA_WR, 16'h1234);
        offer(vpae_pkg::FUNC_DATA_WR, 16'hABCD);               // address wraps to zero
        point_port({2'b00, vpae_pkg::CODE_VRAM_WR}, 16'h0001); // odd address, bytes swapped
        offer(vpae_pkg::FUNC_DATA_WR, 16'h5AA5);
        point_port({2'b00, vpae_pkg::CODE_VRAM_RD}, 16'hFFFE);
        offer(vpae_pkg::FUNC_DATA_RD, 16'h0000);
        offer(vpae_pkg::FUNC_DATA_RD, 16'hFFFF);
        point_port({2'b00, vpae_pkg::CODE_SRAM_WR}, 16'h004E); // last scroll entry
        offer(vpae_pkg::FUNC_DATA_WR, 16'hFFFF);
        offer(vpae_pkg::FUNC_DATA_WR, 16'hFFFF);               // past the end, dropped
        point_port({2'b00, vpae_pkg::CODE_SRAM_RD}, 16'h004E);
        offer(vpae_pkg::FUNC_DATA_RD, 16'h0000);
        offer(vpae_pkg::FUNC_DATA_RD, 16'h0000);               // out of range, refills zero
        write_mode_reg(5'd31, 8'hFF);                          // no such register
        offer(vpae_pkg::FUNC_CTRL_WR, 16'h3FFF);
        offer(vpae_pkg::FUNC_DATA_WR, 16'hFFFF);               // data write clears the latch
        offer(vpae_pkg::FUNC_CTRL_WR, 16'hC000);
        offer(vpae_pkg::FUNC_STATUS_RD, 16'h0000);             // status read clears the latch
        offer(vpae_pkg::FUNC_CTRL_WR,
              {vpae_pkg::MODE_WR_TAG, 1'b0, vpae_pkg::INC_REG, 8'h00});
        point_port(6'h3F, 16'h0000);                           // unselected code
        offer(vpae_pkg::FUNC_DATA_RD, 16'h0000);
        offer(vpae_pkg::FUNC_DATA_RD, 16'h0000);

        // random setups and bursts
        while (n_offered < RANDOM_ITEMS + 30) begin
            sel = $urandom_range(0, 99);
            n   = $urandom_range(1, 8);
            if (sel < 8) begin
                write_mode_reg(vpae_pkg::INC_REG, pick_increment());
            end else if (sel < 43) begin
                case ($urandom_range(0, 2))
                    0:       c4 = vpae_pkg::CODE_VRAM_WR;
                    1:       c4 = vpae_pkg::CODE_CRAM_WR;
                    default: c4 = vpae_pkg::CODE_SRAM_WR;
                endcase
                point_port({2'($urandom), c4}, pick_addr(c4 == vpae_pkg::CODE_VRAM_WR));
                repeat (n) offer(vpae_pkg::FUNC_DATA_WR, 16'($urandom));
            end else if (sel < 80) begin
                case ($urandom_range(0, 2))
                    0:       c4 = vpae_pkg::CODE_VRAM_RD;
                    1:       c4 = vpae_pkg::CODE_CRAM_RD;
                    default: c4 = vpae_pkg::CODE_SRAM_RD;
                endcase
                point_port({2'($urandom), c4}, pick_addr(c4 == vpae_pkg::CODE_VRAM_RD));
                repeat (n)
                    offer(($urandom_range(0, 7) == 0) ? vpae_pkg::FUNC_STATUS_RD
                                                      : vpae_pkg::FUNC_DATA_RD,
                          16'($urandom));
            end else if (sel < 86) begin
                write_mode_reg(5'($urandom), 8'($urandom));
            end else if (sel < 92) begin
                offer(vpae_pkg::FUNC_CTRL_WR, 16'($urandom));
                offer(vpae_pkg::t_func'($urandom_range(1, 3)), 16'($urandom));
            end else begin
                offer(vpae_pkg::t_func'($urandom_range(0, 3)), 16'($urandom));
            end
        end

        wait (n_accepted == n_offered);
        wait (read_words_due.size() == 0);
        repeat (20) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("video_port_access_engine_unit_test: done, clean");
        end else begin
            $display("video_port_access_engine_unit_test: done, errors");
        end
        $finish;
    end

endmodule
